// ----- rtl/mcft_pkg.sv -----
`default_nettype none
package mcft_pkg;

  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_REQ  = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_REQ   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] RES_APPLIED   = 2'd0;
  localparam logic [1:0] RES_MALFORMED = 2'd1;
  localparam logic [1:0] RES_BAD       = 2'd2;
  localparam logic [1:0] RES_IGNORED   = 2'd3;

  localparam logic [1:0] LINK_OFF   = 2'd0;
  localparam logic [1:0] LINK_QUERY = 2'd1;
  localparam logic [1:0] LINK_ON    = 2'd2;

  localparam logic [7:0]  SELECTOR_CTL  = 8'h01;
  localparam logic [7:0]  SVC_FLAG      = 8'h80;
  localparam logic [7:0]  SVC_CTL       = 8'h00;
  localparam logic [7:0]  SVC_DATA      = 8'h01;
  localparam logic [7:0]  CID_BCAST     = 8'hff;
  localparam logic [15:0] MSG_CLIENT    = 16'h0022;
  localparam logic [15:0] MSG_EVENT     = 16'h0022;
  localparam logic [15:0] MSG_PROFILE   = 16'h002D;
  localparam logic [15:0] MSG_START     = 16'h0020;
  localparam logic [15:0] MSG_STOP      = 16'h0021;
  localparam logic [7:0]  EV_CONNECT    = 8'h02;
  localparam logic [7:0]  EV_DISC_A     = 8'h01;
  localparam logic [7:0]  EV_DISC_B     = 8'h03;
  localparam logic [7:0]  CLIENT_OK     = 8'h01;

  localparam int NSLOT = 7;
  localparam logic [2:0] NO_SLOT = 3'd7;

  function automatic logic [2:0] find_slot(input logic [7:0] t);
    logic [2:0] s;
    case (t)
      8'h02:   s = 3'd0;
      8'h01:   s = 3'd1;
      8'h1e:   s = 3'd2;
      8'h21:   s = 3'd3;
      8'h20:   s = 3'd4;
      8'h15:   s = 3'd5;
      8'h16:   s = 3'd6;
      default: s = NO_SLOT;
    endcase
    return s;
  endfunction

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       hres;
    logic [7:0]       svc;
    logic [7:0]       cid;
    logic [15:0]      mtype;
    logic             st_ok;
    logic             c1_len2;
    logic             c1_len4;
    logic [31:0]      c1_val;
    logic [4:0][31:0] addr;
  } rec_t;

  typedef struct packed {
    logic        request_profile;
    logic [31:0] dns_secondary;
    logic [31:0] dns_primary;
    logic [31:0] gateway_address;
    logic [31:0] net_mask;
    logic [31:0] ip_address;
    logic [31:0] call_handle;
    logic [7:0]  client_number;
    logic        service_busy;
    logic        state_changed;
    logic [1:0]  conn_state;
    logic [1:0]  frame_result;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/mcft_front.sv -----
`default_nettype none
module mcft_front #(
  parameter int MAX_FRAME_BYTES = 272
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire  [1:0]        in_action,
  input  wire  [7:0]        in_byte,
  input  wire               in_last,
  output logic              in_ready,
  input  wire               q_full,
  output logic              q_push,
  output mcft_pkg::rec_t    q_rec
);

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 2);
  localparam logic [POS_W-1:0] MAXP = POS_W'(MAX_FRAME_BYTES);
  localparam int NSLOT_L = mcft_pkg::NSLOT;

  localparam logic [1:0] PH_TYPE = 2'd0;
  localparam logic [1:0] PH_LLO  = 2'd1;
  localparam logic [1:0] PH_LHI  = 2'd2;
  localparam logic [1:0] PH_VAL  = 2'd3;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]  sel_r, sel_nxt, flags_r, flags_nxt, svc_r, svc_nxt, cid_r, cid_nxt;
  logic [15:0] qlen_r, qlen_nxt, type_r, type_nxt, size_r, size_nxt;
  logic        stop_r, stop_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [15:0] rem_r, rem_nxt, ilen_r, ilen_nxt, ileft_r, ileft_nxt;
  logic [7:0]  ityp_r, ityp_nxt;
  logic [2:0]  islot_r, islot_nxt, igot_r, igot_nxt;
  logic [NSLOT_L-1:0] found_r, found_nxt;
  logic [15:0] clen_r [NSLOT_L], clen_nxt [NSLOT_L];
  logic [3:0][7:0] cval_r [NSLOT_L], cval_nxt [NSLOT_L];

  logic             acc, is_byte;
  logic [POS_W-1:0] q, hdr, total, qsz, hdrf;
  logic [15:0]      len16;
  logic [2:0]       s;
  logic [1:0]       hres;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign is_byte  = acc && (in_action == mcft_pkg::ACT_BYTE);

  always_comb begin
    pos_nxt = pos_r; sel_nxt = sel_r; flags_nxt = flags_r; svc_nxt = svc_r;
    cid_nxt = cid_r; qlen_nxt = qlen_r; type_nxt = type_r; size_nxt = size_r;
    stop_nxt = stop_r; ph_nxt = ph_r; rem_nxt = rem_r; ilen_nxt = ilen_r;
    ileft_nxt = ileft_r; ityp_nxt = ityp_r; islot_nxt = islot_r; igot_nxt = igot_r;
    found_nxt = found_r; clen_nxt = clen_r; cval_nxt = cval_r;
    q     = pos_r - POS_W'(1);
    hdr   = (svc_r == mcft_pkg::SVC_CTL) ? POS_W'(7) : POS_W'(8);
    len16 = {in_byte, ilen_r[7:0]};
    s     = mcft_pkg::find_slot(ityp_r);
    if (is_byte) begin
      if (pos_r < MAXP + POS_W'(1)) pos_nxt = pos_r + POS_W'(1);
      if (pos_r < MAXP) begin
        if (pos_r == '0) begin
          sel_nxt = in_byte;
        end else if (q == POS_W'(0)) begin
          qlen_nxt = {8'h00, in_byte};
        end else if (q == POS_W'(1)) begin
          qlen_nxt = {in_byte, qlen_r[7:0]};
        end else if (q == POS_W'(2)) begin
          flags_nxt = in_byte;
        end else if (q == POS_W'(3)) begin
          svc_nxt = in_byte;
        end else if (q == POS_W'(4)) begin
          cid_nxt = in_byte;
        end else if (q < hdr) begin
          // transaction id: skip
        end else if (q == hdr) begin
          type_nxt = {8'h00, in_byte};
        end else if (q == hdr + POS_W'(1)) begin
          type_nxt = {in_byte, type_r[7:0]};
        end else if (q == hdr + POS_W'(2)) begin
          size_nxt = {8'h00, in_byte};
        end else if (q == hdr + POS_W'(3)) begin
          size_nxt = {in_byte, size_r[7:0]};
          rem_nxt  = {in_byte, size_r[7:0]};
          ph_nxt   = PH_TYPE;
        end else if (!stop_r) begin
          case (ph_r)
            PH_TYPE: begin
              if (rem_r < 16'd3) begin
                stop_nxt = 1'b1;
              end else begin
                rem_nxt  = rem_r - 16'd3;
                ityp_nxt = in_byte;
                ph_nxt   = PH_LLO;
              end
            end
            PH_LLO: begin
              ilen_nxt = {8'h00, in_byte};
              ph_nxt   = PH_LHI;
            end
            PH_LHI: begin
              ilen_nxt = len16;
              if (len16 > rem_r) begin
                stop_nxt = 1'b1;
              end else begin
                rem_nxt   = rem_r - len16;
                islot_nxt = mcft_pkg::NO_SLOT;
                if (s != mcft_pkg::NO_SLOT && !found_r[s]) begin
                  found_nxt[s] = 1'b1;
                  clen_nxt[s]  = len16;
                  islot_nxt    = s;
                end
                igot_nxt  = 3'd0;
                ileft_nxt = len16;
                ph_nxt    = (len16 != 16'd0) ? PH_VAL : PH_TYPE;
              end
            end
            default: begin
              if (islot_r != mcft_pkg::NO_SLOT && igot_r < 3'd4) begin
                cval_nxt[islot_r][igot_r[1:0]] = in_byte;
                igot_nxt = igot_r + 3'd1;
              end
              ileft_nxt = ileft_r - 16'd1;
              if (ileft_r == 16'd1) ph_nxt = PH_TYPE;
            end
          endcase
        end
      end
    end

    // end-of-packet header checks on the updated fields
    total = pos_nxt;
    qsz   = total - POS_W'(1);
    hdrf  = (svc_nxt == mcft_pkg::SVC_CTL) ? POS_W'(7) : POS_W'(8);
    if (total > MAXP || sel_nxt != mcft_pkg::SELECTOR_CTL) begin
      hres = mcft_pkg::RES_BAD;
    end else if (qsz < POS_W'(5) || 16'(qsz) != qlen_nxt ||
                 flags_nxt != mcft_pkg::SVC_FLAG) begin
      hres = mcft_pkg::RES_MALFORMED;
    end else if (qsz < hdrf + POS_W'(4)) begin
      hres = mcft_pkg::RES_MALFORMED;
    end else if (16'(qsz - hdrf - POS_W'(4)) != size_nxt) begin
      hres = mcft_pkg::RES_MALFORMED;
    end else begin
      hres = mcft_pkg::RES_APPLIED;
    end

    q_rec.kind    = (in_action == mcft_pkg::ACT_BYTE) ? mcft_pkg::KIND_FRAME :
                    (in_action == mcft_pkg::ACT_REQ)  ? mcft_pkg::KIND_REQ :
                                                        mcft_pkg::KIND_READ;
    q_rec.hres    = hres;
    q_rec.svc     = svc_nxt;
    q_rec.cid     = cid_nxt;
    q_rec.mtype   = type_nxt;
    q_rec.st_ok   = found_nxt[0] && clen_nxt[0] == 16'd4 &&
                    cval_nxt[0][0] == 8'h00 && cval_nxt[0][1] == 8'h00;
    q_rec.c1_len2 = found_nxt[1] && clen_nxt[1] == 16'd2;
    q_rec.c1_len4 = found_nxt[1] && clen_nxt[1] == 16'd4;
    q_rec.c1_val  = cval_nxt[1];
    for (int i = 0; i < 5; i++) begin
      q_rec.addr[i] = (found_nxt[i+2] && clen_nxt[i+2] == 16'd4) ? cval_nxt[i+2] : 32'h0;
    end

    q_push = acc && ((in_action == mcft_pkg::ACT_REQ) || (in_action == mcft_pkg::ACT_READ) ||
                     (in_action == mcft_pkg::ACT_BYTE && in_last));

    // drop the packet context once its last beat is taken
    if (is_byte && in_last) begin
      pos_nxt = '0; sel_nxt = '0; flags_nxt = '0; svc_nxt = '0; cid_nxt = '0;
      qlen_nxt = '0; type_nxt = '0; size_nxt = '0; stop_nxt = 1'b0; ph_nxt = PH_TYPE;
      rem_nxt = '0; ilen_nxt = '0; ileft_nxt = '0; ityp_nxt = '0;
      islot_nxt = mcft_pkg::NO_SLOT; igot_nxt = '0; found_nxt = '0;
      for (int i = 0; i < NSLOT_L; i++) begin
        clen_nxt[i] = '0;
        cval_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; sel_r <= '0; flags_r <= '0; svc_r <= '0; cid_r <= '0;
      qlen_r <= '0; type_r <= '0; size_r <= '0; stop_r <= 1'b0; ph_r <= PH_TYPE;
      rem_r <= '0; ilen_r <= '0; ileft_r <= '0; ityp_r <= '0;
      islot_r <= mcft_pkg::NO_SLOT; igot_r <= '0; found_r <= '0;
      for (int i = 0; i < NSLOT_L; i++) begin
        clen_r[i] <= '0;
        cval_r[i] <= '0;
      end
    end else begin
      pos_r <= pos_nxt; sel_r <= sel_nxt; flags_r <= flags_nxt; svc_r <= svc_nxt;
      cid_r <= cid_nxt; qlen_r <= qlen_nxt; type_r <= type_nxt; size_r <= size_nxt;
      stop_r <= stop_nxt; ph_r <= ph_nxt; rem_r <= rem_nxt; ilen_r <= ilen_nxt;
      ileft_r <= ileft_nxt; ityp_r <= ityp_nxt; islot_r <= islot_nxt; igot_r <= igot_nxt;
      found_r <= found_nxt;
      clen_r  <= clen_nxt;
      cval_r  <= cval_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mcft_fifo.sv -----
`default_nettype none
module mcft_fifo (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  mcft_pkg::rec_t  wdata,
  output logic            full,
  input  wire             pop,
  output logic            not_empty,
  output mcft_pkg::rec_t  rdata
);

  mcft_pkg::rec_t mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign rdata     = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (pop)  rptr_r <= !rptr_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mcft_back.sv -----
`default_nettype none
module mcft_back (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             q_not_empty,
  input  mcft_pkg::rec_t  q_rec,
  output logic            q_pop,
  output logic            out_valid,
  input  wire             out_ready,
  output mcft_pkg::res_t  out_res
);

  logic [1:0]       link_r, link_nxt;
  logic             chg_r, chg_nxt, busy_r, busy_nxt;
  logic [7:0]       client_r, client_nxt;
  logic [31:0]      handle_r, handle_nxt;
  logic [4:0][31:0] addr_r, addr_nxt;
  logic             ov_r, ov_nxt;
  mcft_pkg::res_t   res_r, res_nxt;
  logic [1:0]       fres;
  logic             prof, emit_chg;

  assign q_pop     = q_not_empty && (!ov_r || out_ready);
  assign out_valid = ov_r;
  assign out_res   = res_r;

  always_comb begin
    link_nxt = link_r; chg_nxt = chg_r; busy_nxt = busy_r; client_nxt = client_r;
    handle_nxt = handle_r; addr_nxt = addr_r;
    ov_nxt = ov_r && !out_ready;
    res_nxt = res_r;
    fres = q_rec.hres;
    prof = 1'b0;
    emit_chg = chg_r;
    if (q_pop) begin
      case (q_rec.kind)
        mcft_pkg::KIND_REQ: begin
          busy_nxt = 1'b1;
        end
        mcft_pkg::KIND_READ: begin
          fres     = mcft_pkg::RES_IGNORED;
          chg_nxt  = 1'b0;
          ov_nxt   = 1'b1;
        end
        default: begin
          ov_nxt = 1'b1;
          if (q_rec.hres == mcft_pkg::RES_APPLIED) begin
            if (q_rec.svc == mcft_pkg::SVC_CTL) begin
              if (q_rec.mtype == mcft_pkg::MSG_CLIENT && q_rec.st_ok && q_rec.c1_len2 &&
                  q_rec.c1_val[7:0] == mcft_pkg::CLIENT_OK) begin
                client_nxt = q_rec.c1_val[15:8];
                busy_nxt   = 1'b0;
              end
            end else if (q_rec.svc != mcft_pkg::SVC_DATA) begin
              fres = mcft_pkg::RES_IGNORED;
            end else if (q_rec.cid == client_r) begin
              if (q_rec.mtype == mcft_pkg::MSG_STOP) begin
                if (q_rec.st_ok) begin
                  link_nxt = mcft_pkg::LINK_OFF;
                  chg_nxt  = 1'b1;
                end
              end else if (q_rec.mtype == mcft_pkg::MSG_START) begin
                if (q_rec.st_ok && q_rec.c1_len4) handle_nxt = q_rec.c1_val;
              end else if (q_rec.mtype == mcft_pkg::MSG_PROFILE) begin
                if (link_r == mcft_pkg::LINK_QUERY) begin
                  addr_nxt = q_rec.addr;
                  link_nxt = mcft_pkg::LINK_ON;
                  chg_nxt  = 1'b1;
                end
              end
              busy_nxt = 1'b0;
            end else if (q_rec.cid == mcft_pkg::CID_BCAST) begin
              if (q_rec.mtype == mcft_pkg::MSG_EVENT && q_rec.c1_len2) begin
                if (q_rec.c1_val[7:0] == mcft_pkg::EV_DISC_A ||
                    q_rec.c1_val[7:0] == mcft_pkg::EV_DISC_B) begin
                  link_nxt = mcft_pkg::LINK_OFF;
                  chg_nxt  = 1'b1;
                end else if (q_rec.c1_val[7:0] == mcft_pkg::EV_CONNECT) begin
                  link_nxt = mcft_pkg::LINK_QUERY;
                  chg_nxt  = 1'b1;
                  prof     = 1'b1;
                end
              end
            end else begin
              fres = mcft_pkg::RES_IGNORED;
            end
          end
          emit_chg = chg_nxt;
        end
      endcase
      res_nxt.frame_result    = fres;
      res_nxt.conn_state      = link_nxt;
      res_nxt.state_changed   = emit_chg;
      res_nxt.service_busy    = busy_nxt;
      res_nxt.client_number   = client_nxt;
      res_nxt.call_handle     = handle_nxt;
      res_nxt.ip_address      = addr_nxt[0];
      res_nxt.net_mask        = addr_nxt[1];
      res_nxt.gateway_address = addr_nxt[2];
      res_nxt.dns_primary     = addr_nxt[3];
      res_nxt.dns_secondary   = addr_nxt[4];
      res_nxt.request_profile = prof;
      // a request beat leaves the held result alone
      if (q_rec.kind == mcft_pkg::KIND_REQ) res_nxt = res_r;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r <= mcft_pkg::LINK_OFF; chg_r <= 1'b0; busy_r <= 1'b1; client_r <= '0;
      handle_r <= '0; addr_r <= '0; ov_r <= 1'b0;
    end else begin
      link_r <= link_nxt; chg_r <= chg_nxt; busy_r <= busy_nxt; client_r <= client_nxt;
      handle_r <= handle_nxt; addr_r <= addr_nxt; ov_r <= ov_nxt;
    end
  end

`ifndef SYNTHESIS
  a_req_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_rec.kind == mcft_pkg::KIND_REQ |=> busy_r)
    else $error("request beat did not set busy");
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_rec.kind == mcft_pkg::KIND_READ |=>
      ov_r && res_r.frame_result == mcft_pkg::RES_IGNORED && !res_r.request_profile && !chg_r)
    else $error("status read result wrong");
  a_prof_query: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && res_r.request_profile |-> res_r.conn_state == mcft_pkg::LINK_QUERY)
    else $error("profile request without query state");
  a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |-> !q_pop)
    else $error("queue popped into a stalled result");
`endif

endmodule
`default_nettype wire

// ----- rtl/modem_control_frame_tracker.sv -----
`default_nettype none
// Channel | Dir | tdata                          | tuser       | tlast
// in_     | in  | [7:0] data_byte                | [1:0] action| last_byte
// out_    | out | see out_tdata field list below | -           | -
//
// One beat per cycle on the input while in_tready is high. A result is queued
// when its deciding beat is taken and moves to the result register once the
// output is free, raising out_tvalid. The front parser updates header and TLV
// capture registers as each byte is taken; a two-entry queue feeds the back
// stage that applies messages to the link state and holds the result register.
// Reset (rst_n low, synchronous) clears the packet context, link offline, busy set.
// A stalled output holds the result; the queue fills, then in_tready drops.
module modem_control_frame_tracker #(
  parameter int MAX_FRAME_BYTES = 272
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [7:0]   in_tdata,   // [7:0] data_byte
  input  wire  [1:0]   in_tuser,   // [1:0] action
  input  wire          in_tlast,
  output logic         out_tvalid,
  input  wire          out_tready,
  // [1:0] frame_result, [3:2] conn_state, [4] state_changed, [5] service_busy,
  // [13:6] client_number, [45:14] call_handle, [77:46] ip_address,
  // [109:78] net_mask, [141:110] gateway_address, [173:142] dns_primary,
  // [205:174] dns_secondary, [206] request_profile, [207] zero
  output logic [207:0] out_tdata
);

  mcft_pkg::rec_t push_rec, pop_rec;
  mcft_pkg::res_t res;
  logic push, full, pop, not_empty;

  mcft_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_action(in_tuser),
    .in_byte(in_tdata), .in_last(in_tlast), .in_ready(in_tready),
    .q_full(full), .q_push(push), .q_rec(push_rec)
  );

  mcft_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .wdata(push_rec), .full(full),
    .pop(pop), .not_empty(not_empty), .rdata(pop_rec)
  );

  mcft_back u_back (
    .clk(clk), .rst_n(rst_n), .q_not_empty(not_empty), .q_rec(pop_rec), .q_pop(pop),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res)
  );

  assign out_tdata = {1'b0, res};

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
module tb;

  localparam int FRAME_MAX = 272;
  localparam logic [1:0] ACT_NOP = 2'd3;

  class link_scoreboard;
    // connection context
    logic [1:0]  link;
    bit          changed, busy;
    logic [7:0]  client_num;
    logic [31:0] handle;
    logic [31:0] addrs [5];
    // packet context
    int unsigned pos, qlen, tfield, sfield;
    logic [7:0]  sel, flags, svc, cid;
    bit          stopped;
    int unsigned phase, rem, ilen, ileft, igot;
    logic [7:0]  itype;
    int          islot;
    bit          found [7];
    int unsigned clen [7];
    logic [7:0]  cval [7][4];
    mcft_pkg::res_t pending [$];
    int          errors;

    function new();
      link = mcft_pkg::LINK_OFF; changed = 0; busy = 1; client_num = 0; handle = 0;
      foreach (addrs[i]) addrs[i] = 0;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos = 0; qlen = 0; tfield = 0; sfield = 0;
      sel = 0; flags = 0; svc = 0; cid = 0;
      stopped = 0; phase = 0; rem = 0; ilen = 0; ileft = 0; igot = 0;
      itype = 0; islot = -1;
      for (int i = 0; i < 7; i++) begin
        found[i] = 0; clen[i] = 0;
        for (int j = 0; j < 4; j++) cval[i][j] = 0;
      end
    endfunction

    function int slot_of(logic [7:0] t);
      case (t)
        8'h02: return 0;
        8'h01: return 1;
        8'h1e: return 2;
        8'h21: return 3;
        8'h20: return 4;
        8'h15: return 5;
        8'h16: return 6;
        default: return -1;
      endcase
    endfunction

    function void walk_tlv(logic [7:0] b);
      int s;
      if (stopped) return;
      case (phase)
        0: begin
          if (rem < 3) begin stopped = 1; return; end
          rem -= 3; itype = b; phase = 1;
        end
        1: begin ilen = b; phase = 2; end
        2: begin
          ilen |= int'(b) << 8;
          if (ilen > rem) begin stopped = 1; return; end
          rem -= ilen;
          s = slot_of(itype);
          islot = -1;
          if (s >= 0 && !found[s]) begin
            found[s] = 1; clen[s] = ilen; islot = s;
          end
          igot = 0; ileft = ilen;
          phase = (ileft != 0) ? 3 : 0;
        end
        default: begin
          if (islot >= 0 && igot < 4) begin
            cval[islot][igot] = b; igot++;
          end
          ileft--;
          if (ileft == 0) phase = 0;
        end
      endcase
    endfunction

    function void frame_byte(logic [7:0] b);
      int unsigned p, q, hdr;
      p = pos;
      if (p < FRAME_MAX + 1) pos = p + 1;
      if (p >= FRAME_MAX) return;
      if (p == 0) begin sel = b; return; end
      q = p - 1;
      hdr = (svc == mcft_pkg::SVC_CTL) ? 7 : 8;
      if (q == 0) qlen = b;
      else if (q == 1) qlen |= int'(b) << 8;
      else if (q == 2) flags = b;
      else if (q == 3) svc = b;
      else if (q == 4) cid = b;
      else if (q < hdr) begin end
      else if (q == hdr) tfield = b;
      else if (q == hdr + 1) tfield |= int'(b) << 8;
      else if (q == hdr + 2) sfield = b;
      else if (q == hdr + 3) begin
        sfield |= int'(b) << 8; rem = sfield; phase = 0;
      end else walk_tlv(b);
    endfunction

    function bit has(int s, int unsigned sz);
      return found[s] && clen[s] == sz;
    endfunction

    function logic [31:0] word_of(int s);
      return {cval[s][3], cval[s][2], cval[s][1], cval[s][0]};
    endfunction

    function bit status_good();
      return has(0, 4) && cval[0][0] == 0 && cval[0][1] == 0;
    endfunction

    function void go_link(logic [1:0] s);
      link = s; changed = 1;
    endfunction

    function logic [1:0] apply_frame(output bit prof);
      int unsigned qsz, hdr, rest;
      prof = 0;
      if (pos > FRAME_MAX || sel != mcft_pkg::SELECTOR_CTL) return mcft_pkg::RES_BAD;
      qsz = pos - 1;
      if (qsz < 5 || qsz != qlen || flags != mcft_pkg::SVC_FLAG)
        return mcft_pkg::RES_MALFORMED;
      hdr = (svc == mcft_pkg::SVC_CTL) ? 7 : 8;
      if (qsz < hdr) return mcft_pkg::RES_MALFORMED;
      rest = qsz - hdr;
      if (rest < 4) return mcft_pkg::RES_MALFORMED;
      rest -= 4;
      if (rest != sfield) return mcft_pkg::RES_MALFORMED;
      if (svc == mcft_pkg::SVC_CTL) begin
        if (tfield == mcft_pkg::MSG_CLIENT && status_good() && has(1, 2) &&
            cval[1][0] == mcft_pkg::CLIENT_OK) begin
          client_num = cval[1][1]; busy = 0;
        end
        return mcft_pkg::RES_APPLIED;
      end
      if (svc != mcft_pkg::SVC_DATA) return mcft_pkg::RES_IGNORED;
      if (cid == client_num) begin
        if (tfield == mcft_pkg::MSG_STOP) begin
          if (status_good()) go_link(mcft_pkg::LINK_OFF);
        end else if (tfield == mcft_pkg::MSG_START) begin
          if (status_good() && has(1, 4)) handle = word_of(1);
        end else if (tfield == mcft_pkg::MSG_PROFILE) begin
          if (link == mcft_pkg::LINK_QUERY) begin
            for (int i = 0; i < 5; i++) addrs[i] = has(2 + i, 4) ? word_of(2 + i) : 0;
            go_link(mcft_pkg::LINK_ON);
          end
        end
        busy = 0;
        return mcft_pkg::RES_APPLIED;
      end
      if (cid == mcft_pkg::CID_BCAST) begin
        if (tfield == mcft_pkg::MSG_EVENT && has(1, 2)) begin
          if (cval[1][0] == mcft_pkg::EV_DISC_A || cval[1][0] == mcft_pkg::EV_DISC_B)
            go_link(mcft_pkg::LINK_OFF);
          else if (cval[1][0] == mcft_pkg::EV_CONNECT) begin
            go_link(mcft_pkg::LINK_QUERY); prof = 1;
          end
        end
        return mcft_pkg::RES_APPLIED;
      end
      return mcft_pkg::RES_IGNORED;
    endfunction

    function mcft_pkg::res_t snapshot(logic [1:0] r, bit chg, bit prof);
      mcft_pkg::res_t e;
      e.frame_result = r; e.conn_state = link; e.state_changed = chg;
      e.service_busy = busy; e.client_number = client_num; e.call_handle = handle;
      e.ip_address = addrs[0]; e.net_mask = addrs[1]; e.gateway_address = addrs[2];
      e.dns_primary = addrs[3]; e.dns_secondary = addrs[4];
      e.request_profile = prof;
      return e;
    endfunction

    function void note_beat(logic [1:0] act, logic [7:0] b, bit lst);
      bit prof;
      logic [1:0] r;
      if (act == mcft_pkg::ACT_REQ) busy = 1;
      else if (act == mcft_pkg::ACT_READ) begin
        pending.push_back(snapshot(mcft_pkg::RES_IGNORED, changed, 0));
        changed = 0;
      end else if (act == mcft_pkg::ACT_BYTE) begin
        frame_byte(b);
        if (lst) begin
          r = apply_frame(prof);
          pending.push_back(snapshot(r, changed, prof));
          clear_frame();
        end
      end
    endfunction

    function void field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s expected %0h got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(mcft_pkg::res_t a);
      mcft_pkg::res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      field("frame_result", e.frame_result, a.frame_result);
      field("conn_state", e.conn_state, a.conn_state);
      field("state_changed", e.state_changed, a.state_changed);
      field("service_busy", e.service_busy, a.service_busy);
      field("client_number", e.client_number, a.client_number);
      field("call_handle", e.call_handle, a.call_handle);
      field("ip_address", e.ip_address, a.ip_address);
      field("net_mask", e.net_mask, a.net_mask);
      field("gateway_address", e.gateway_address, a.gateway_address);
      field("dns_primary", e.dns_primary, a.dns_primary);
      field("dns_secondary", e.dns_secondary, a.dns_secondary);
      field("request_profile", e.request_profile, a.request_profile);
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [7:0]   in_tdata = 0;
  logic [1:0]   in_tuser = 0;
  logic         in_tlast = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [207:0] out_tdata;

  link_scoreboard sb = new();
  bit quiet = 0;
  bit hold_req = 0;
  int beats = 0;
  logic [7:0] prof_types[5] = '{8'h1e, 8'h21, 8'h20, 8'h15, 8'h16};

  always #10 clk = ~clk;

  modem_control_frame_tracker dut (.*);

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_beat(in_tuser, in_tdata, in_tlast);
      beats++;
    end
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(mcft_pkg::res_t'(out_tdata[206:0]));
  end

  initial begin
    #20ms;
    $display("modem_control_frame_tracker verification failed");
    $finish;
  end

  // receiver: random stalls plus one long hold-off when asked
  initial begin
    bit held;
    held = 0;
    @(posedge rst_n);
    forever begin
      if (hold_req && !held) begin
        out_tready <= 0;
        repeat (300) @(posedge clk);
        held = 1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_tready <= 1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_beat(logic [1:0] act, logic [7:0] b, bit lst);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= act;
    in_tdata  <= b;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic void add_tlv(ref logic [7:0] body[$], input logic [7:0] t,
                                  input int len, input logic [31:0] val);
    body.push_back(t);
    body.push_back(len[7:0]);
    body.push_back(len[15:8]);
    for (int i = 0; i < len; i++) body.push_back(i < 4 ? val[8*i +: 8] : 8'($urandom));
  endfunction

  // wrap a TLV area in selector, mux header and message header
  task automatic send_frame(logic [7:0] svc, logic [7:0] cid, logic [15:0] mtype,
                            logic [7:0] body[$], int mangle = 0, bit mix = 0);
    logic [7:0] f[$];
    int n, k;
    n = body.size();
    f.push_back(mcft_pkg::SELECTOR_CTL);
    f.push_back(8'h00); f.push_back(8'h00);
    f.push_back(mcft_pkg::SVC_FLAG); f.push_back(svc); f.push_back(cid);
    repeat (svc == mcft_pkg::SVC_CTL ? 2 : 3) f.push_back(8'($urandom));
    f.push_back(mtype[7:0]); f.push_back(mtype[15:8]);
    f.push_back(n[7:0]); f.push_back(n[15:8]);
    foreach (body[i]) f.push_back(body[i]);
    k = f.size() - 1;
    f[1] = k[7:0]; f[2] = k[15:8];
    case (mangle)
      1: begin k = $urandom_range(0, f.size() - 1); f[k] = f[k] ^ (8'h1 << $urandom_range(0, 7)); end
      2: f = f[0:$urandom_range(0, f.size() - 1)];
      3: f.push_back(8'($urandom));
      default: ;
    endcase
    foreach (f[i]) begin
      if (mix && $urandom_range(0, 15) == 0)
        send_beat(2'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
      send_beat(mcft_pkg::ACT_BYTE, f[i], i == f.size() - 1);
    end
  endtask

  task automatic send_noise(int n);
    for (int i = 0; i < n; i++) send_beat(mcft_pkg::ACT_BYTE, 8'($urandom), i == n - 1);
  endtask

  task automatic random_frame();
    logic [7:0] body[$];
    logic [7:0] cid;
    logic [15:0] mtype;
    logic [7:0] svc;
    int pick, mangle, nx;
    pick = $urandom_range(0, 5);
    mangle = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    cid = ($urandom_range(0, 5) == 0) ? 8'($urandom) : sb.client_num;
    svc = mcft_pkg::SVC_DATA;
    // status: mostly success
    if ($urandom_range(0, 6) != 0)
      add_tlv(body, 8'h02, ($urandom_range(0, 7) == 0) ? 3 : 4,
              ($urandom_range(0, 4) == 0) ? $urandom :
                                            {16'($urandom_range(0, 65535)), 16'h0});
    case (pick)
      0: begin
        svc = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(2, 255)) : mcft_pkg::SVC_CTL;
        mtype = ($urandom_range(0, 6) == 0) ? 16'($urandom) : mcft_pkg::MSG_CLIENT;
        add_tlv(body, 8'h01, ($urandom_range(0, 6) == 0) ? 1 : 2,
                {16'h0, 8'($urandom),
                 ($urandom_range(0, 5) == 0) ? 8'($urandom) : mcft_pkg::CLIENT_OK});
      end
      1: begin
        mtype = mcft_pkg::MSG_START;
        add_tlv(body, 8'h01, ($urandom_range(0, 6) == 0) ? 2 : 4, $urandom);
      end
      2: mtype = mcft_pkg::MSG_STOP;
      3: mtype = mcft_pkg::MSG_PROFILE;
      default: begin
        cid = ($urandom_range(0, 7) == 0) ? 8'($urandom) : mcft_pkg::CID_BCAST;
        mtype = ($urandom_range(0, 7) == 0) ? 16'($urandom) : mcft_pkg::MSG_EVENT;
        add_tlv(body, 8'h01, ($urandom_range(0, 7) == 0) ? 3 : 2,
                {24'h0, ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(1, 3))});
      end
    endcase
    if (pick == 3) begin
      body.delete();
      if ($urandom_range(0, 3) != 0) add_tlv(body, 8'h02, 4, 0);
      foreach (prof_types[t])
        if ($urandom_range(0, 5) != 0)
          add_tlv(body, prof_types[t], ($urandom_range(0, 7) == 0) ? 3 : 4, $urandom);
    end
    // extras: unknown types, duplicates, empty items
    nx = $urandom_range(0, 2);
    repeat (nx) add_tlv(body, 8'($urandom), $urandom_range(0, 6), $urandom);
    if ($urandom_range(0, 6) == 0) body.shuffle();
    send_frame(svc, cid, mtype, body, mangle, 1);
  endtask

  initial begin
    logic [7:0] body[$];
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: status read, request, ignored action code
    send_beat(mcft_pkg::ACT_READ, 8'h00, 0);
    send_beat(mcft_pkg::ACT_REQ, 8'hff, 1);
    send_beat(ACT_NOP, 8'h5a, 1);
    // client id assignment
    body.delete(); add_tlv(body, 8'h02, 4, 0); add_tlv(body, 8'h01, 2, 32'h0000_3701);
    send_frame(mcft_pkg::SVC_CTL, 8'h00, mcft_pkg::MSG_CLIENT, body);
    // start reply with call handle
    body.delete(); add_tlv(body, 8'h02, 4, 0); add_tlv(body, 8'h01, 4, 32'hffff_ffff);
    send_frame(mcft_pkg::SVC_DATA, 8'h37, mcft_pkg::MSG_START, body);
    // connect broadcast, then profile
    body.delete(); add_tlv(body, 8'h01, 2, {24'h0, mcft_pkg::EV_CONNECT});
    send_frame(mcft_pkg::SVC_DATA, mcft_pkg::CID_BCAST, mcft_pkg::MSG_EVENT, body);
    body.delete();
    foreach (prof_types[t]) add_tlv(body, prof_types[t], 4, 32'h0a00_0001 + t);
    add_tlv(body, 8'h1e, 4, 32'h1234_5678);
    send_frame(mcft_pkg::SVC_DATA, 8'h37, mcft_pkg::MSG_PROFILE, body);
    send_beat(mcft_pkg::ACT_READ, 8'h00, 0);
    // network stop, disconnect broadcast
    body.delete(); add_tlv(body, 8'h02, 4, 0);
    send_frame(mcft_pkg::SVC_DATA, 8'h37, mcft_pkg::MSG_STOP, body);
    body.delete(); add_tlv(body, 8'h01, 2, {24'h0, mcft_pkg::EV_DISC_B});
    send_frame(mcft_pkg::SVC_DATA, mcft_pkg::CID_BCAST, mcft_pkg::MSG_EVENT, body);
    // bad selector, flipped bit, unknown service, foreign client, oversize, tiny
    send_noise(1);
    body.delete(); add_tlv(body, 8'h02, 4, 0);
    send_frame(mcft_pkg::SVC_DATA, 8'h37, mcft_pkg::MSG_STOP, body, 1);
    send_frame(8'h05, 8'h37, mcft_pkg::MSG_STOP, body);
    send_frame(mcft_pkg::SVC_DATA, 8'h12, mcft_pkg::MSG_STOP, body);
    body.delete(); add_tlv(body, 8'h99, 270, 0);
    send_frame(mcft_pkg::SVC_DATA, 8'h37, mcft_pkg::MSG_STOP, body);
    send_beat(mcft_pkg::ACT_BYTE, mcft_pkg::SELECTOR_CTL, 0);
    send_beat(mcft_pkg::ACT_BYTE, 8'h03, 1);

    // random: mostly well-formed frames, some noise and stray actions
    while (beats < 830) begin
      if (beats > 350 && !hold_req) hold_req = 1;
      if (beats > 740) quiet = 1;
      case ($urandom_range(0, 9))
        0: send_noise($urandom_range(1, 12));
        1: send_beat(2'($urandom_range(1, 2)), 8'($urandom), 1'($urandom));
        default: random_frame();
      endcase
    end
    // stop driving, then wait for every expected result
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("modem_control_frame_tracker verification clean");
    else
      $display("modem_control_frame_tracker verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mcft_pkg.sv
rtl/mcft_front.sv
rtl/mcft_fifo.sv
rtl/mcft_back.sv
rtl/modem_control_frame_tracker.sv
dv/tb.sv
